// ===== rtl/dscs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscs_pkg: shared definitions for the delayed sparse coupling sum block
// Default sizes, command codes, register indexes, the sequencer state type
// and the control word of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package dscs_pkg;

  // Default sizes of the tables.
  localparam int NODES_DEF   = 64;
  localparam int EDGES_DEF   = 4096;
  localparam int HORIZON_DEF = 256;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 48;

  // Configuration register map, indexed by paddr[2].
  localparam logic       REG_NODE_COUNT   = 1'b0;
  localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_ROW_START = 2'd0,
    CMD_EDGE      = 2'd1,
    CMD_HISTORY   = 2'd2,
    CMD_COMPUTE   = 2'd3
  } command_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_ROW_WAIT,
    S_EDGE,
    S_EDGE_WAIT,
    S_MAC_NOW,
    S_MAC_NEXT,
    S_ACC_NEXT,
    S_EMIT
  } state_t;

  // Control word for the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;     // zero both accumulators
    logic mul_en;    // capture op_a * op_b in the product register
    logic add_en;    // add the product register into an accumulator
    logic add_next;  // 0 selects the "now" sum, 1 the "next" sum
  } mac_ctrl_t;

endpackage

// ===== rtl/dscs_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscs_mac: shared multiply-accumulate unit
// One 16x16 signed multiplier with a registered product, feeding one adder
// into either of two 48-bit accumulators.
// ----------------------------------------------------------------------------
module dscs_mac (
  input  logic                                    clk,
  input  dscs_pkg::mac_ctrl_t                     ctrl,
  input  logic signed [dscs_pkg::SAMPLE_W-1:0]    op_a,
  input  logic signed [dscs_pkg::SAMPLE_W-1:0]    op_b,
  output logic signed [dscs_pkg::ACC_W-1:0]       acc_now,
  output logic signed [dscs_pkg::ACC_W-1:0]       acc_next
);

  localparam int PROD_W = 2 * dscs_pkg::SAMPLE_W;

  logic signed [PROD_W-1:0]        product;
  logic signed [dscs_pkg::ACC_W-1:0] product_ext;

  // The product is exact in 32 bits; extend it to the accumulator width.
  assign product_ext = {{(dscs_pkg::ACC_W - PROD_W){product[PROD_W-1]}}, product};

  // Multiplier stage.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      product <= op_a * op_b;
    end
  end

  // Accumulate stage; sums wrap at 48 bits.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_now  <= '0;
      acc_next <= '0;
    end else if (ctrl.add_en) begin
      if (ctrl.add_next) begin
        acc_next <= acc_next + product_ext;
      end else begin
        acc_now <= acc_now + product_ext;
      end
    end
  end

endmodule

// ===== rtl/delayed_sparse_coupling_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_sparse_coupling_sum: delayed sparse coupling sums over a CSR table
// Holds row starts, edges and a per-node ring of past samples in memories,
// and on a compute word emits two coupling sums per node, up to node_count nodes.
// ----------------------------------------------------------------------------
// Write words (row start, edge, history sample) are taken while idle. Per node,
// a compute word reads the row bounds; per edge it reads the edge, then history,
// then multiplies and accumulates through the single shared multiply-accumulate
// unit, which forms the "now" and "next" products one after the other.
// No new word is taken until the compute has loaded its last result into the
// output register. Reset clears the sequencer and output valid and sets
// node_count to 64; the memories are not cleared and hold garbage until written.
module delayed_sparse_coupling_sum #(
  parameter int NODES   = dscs_pkg::NODES_DEF,
  parameter int EDGES   = dscs_pkg::EDGES_DEF,
  parameter int HORIZON = dscs_pkg::HORIZON_DEF
) (
  input  logic               clk,
  input  logic               rst,

  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [6:0]         node,
  input  logic [11:0]        edge_slot,
  input  logic [12:0]        row_start,
  input  logic [5:0]         source_node,
  input  logic signed [15:0] weight,
  input  logic [7:0]         delay,
  input  logic [7:0]         history_slot,
  input  logic signed [15:0] sample,
  input  logic [7:0]         time_slot,

  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         target_node,
  output logic signed [47:0] coupling_now,
  output logic signed [47:0] coupling_next,
  output logic               last,

  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Index widths derived from the table sizes.
  localparam int NW         = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW         = $clog2(NODES + 1);
  localparam int EW         = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int EC         = $clog2(EDGES + 1);
  localparam int HW         = $clog2(HORIZON);
  localparam int HIST_DEPTH = NODES * (1 << HW);
  localparam int EDGE_W     = 6 + 16 + 8;

  // Small table that reduces an 8-bit slot or delay modulo the horizon.
  typedef logic [HW-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int k = 0; k < 256; k++) begin
      tab[k] = HW'(k % HORIZON);
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // Memories.
  logic [12:0]         row_mem  [NODES + 1];
  logic [EDGE_W-1:0]   edge_mem [EDGES];
  logic signed [15:0]  hist_mem [HIST_DEPTH];

  // Sequencer and datapath registers.
  dscs_pkg::state_t    state, state_next;
  logic [6:0]          node_count;
  logic [CW-1:0]       node_idx;
  logic [CW-1:0]       count_q;
  logic [HW-1:0]       t_q;
  logic [EC-1:0]       edge_ptr;
  logic [EC-1:0]       edge_end;
  logic [12:0]         rs_lo;
  logic [12:0]         rs_hi;
  logic [EDGE_W-1:0]   edge_q;
  logic signed [15:0]  w_eff;
  logic signed [15:0]  h_now;
  logic signed [15:0]  h_next;
  logic                out_valid_next;

  // Sequencer outputs.
  logic                row_rd;
  logic                row_load;
  logic                edge_rd;
  logic                hist_rd;
  logic                hist_sel;
  logic                edge_step;
  logic                emit_load;
  logic                compute_start;
  dscs_pkg::mac_ctrl_t mac_ctrl;

  // Combinational helpers.
  logic                in_acc;
  logic                cfg_wr;
  logic [CW-1:0]       count_c;
  logic [EC-1:0]       lo_c;
  logic [EC-1:0]       hi_c;
  logic                last_c;
  logic                edge_done_c;
  logic                emit_ok;
  logic [5:0]          src_q;
  logic signed [15:0]  w_q;
  logic [7:0]          d_q;
  logic                src_ok;
  logic [NW-1:0]       src_idx;
  logic [HW-1:0]       dm;
  logic [HW-1:0]       p1;
  logic [HW-1:0]       p2;
  logic signed [15:0]  mac_b;
  logic signed [47:0]  acc_now;
  logic signed [47:0]  acc_next;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration register and read-back.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dscs_pkg::NODE_COUNT_RESET;
    end else if (cfg_wr && paddr[2] == dscs_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[6:0];
    end
  end

  always_comb begin
    if (paddr[2] == dscs_pkg::REG_NODE_COUNT) begin
      prdata = {25'd0, node_count};
    end else begin
      prdata = '0;
    end
  end

  // Node count limited to the table size.
  assign count_c = (32'(node_count) > 32'(NODES)) ? CW'(NODES) : CW'(node_count);

  // Row bounds clamped to the edge table.
  assign lo_c = (32'(rs_lo) > 32'(EDGES)) ? EC'(EDGES) : EC'(rs_lo);
  assign hi_c = (32'(rs_hi) > 32'(EDGES)) ? EC'(EDGES) : EC'(rs_hi);

  assign last_c      = (node_idx + CW'(1)) == count_q;
  assign edge_done_c = (edge_ptr + EC'(1)) == edge_end;
  assign emit_ok     = !out_valid || !out_stall;

  // Fields of the edge just read.
  assign src_q   = edge_q[29:24];
  assign w_q     = edge_q[23:8];
  assign d_q     = edge_q[7:0];
  assign src_ok  = 32'(src_q) < 32'(NODES);
  assign src_idx = src_ok ? NW'(src_q) : '0;
  assign dm      = MOD_TAB[d_q];

  // Ring slots for time minus delay and the slot one step later.
  always_comb begin
    if (t_q >= dm) begin
      p1 = t_q - dm;
    end else begin
      p1 = HW'((HW + 1)'(t_q) + (HW + 1)'(HORIZON) - (HW + 1)'(dm));
    end
    if (p1 == HW'(HORIZON - 1)) begin
      p2 = '0;
    end else begin
      p2 = p1 + HW'(1);
    end
  end

  // Row start memory: write port from the input, two read ports.
  always_ff @(posedge clk) begin
    if (in_acc && command == dscs_pkg::CMD_ROW_START && 32'(node) <= 32'(NODES)) begin
      row_mem[CW'(node)] <= row_start;
    end
    if (row_rd) begin
      rs_lo <= row_mem[node_idx];
      rs_hi <= row_mem[node_idx + CW'(1)];
    end
  end

  // Edge memory holds source, weight and delay in one word.
  always_ff @(posedge clk) begin
    if (in_acc && command == dscs_pkg::CMD_EDGE && 32'(edge_slot) < 32'(EDGES)) begin
      edge_mem[EW'(edge_slot)] <= {source_node, weight, delay};
    end
    if (edge_rd) begin
      edge_q <= edge_mem[edge_ptr[EW-1:0]];
    end
  end

  // History memory, node-major with a power-of-two stride per node.
  always_ff @(posedge clk) begin
    if (in_acc && command == dscs_pkg::CMD_HISTORY && 32'(node) < 32'(NODES)
        && 32'(history_slot) < 32'(HORIZON)) begin
      hist_mem[{NW'(node), HW'(history_slot)}] <= sample;
    end
    if (hist_rd) begin
      h_now  <= hist_mem[{src_idx, p1}];
      h_next <= hist_mem[{src_idx, p2}];
    end
  end

  // Datapath registers steered by the sequencer.
  always_ff @(posedge clk) begin
    if (compute_start) begin
      node_idx <= '0;
      count_q  <= count_c;
      t_q      <= MOD_TAB[time_slot];
    end else if (emit_load) begin
      node_idx <= node_idx + CW'(1);
    end
    if (row_load) begin
      edge_ptr <= lo_c;
      edge_end <= hi_c;
    end else if (edge_step) begin
      edge_ptr <= edge_ptr + EC'(1);
    end
    // An edge to a missing source contributes nothing.
    if (hist_rd) begin
      w_eff <= src_ok ? w_q : 16'sd0;
    end
  end

  // Shared multiply-accumulate unit.
  assign mac_b = hist_sel ? h_next : h_now;

  dscs_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .op_a     (w_eff),
    .op_b     (mac_b),
    .acc_now  (acc_now),
    .acc_next (acc_next)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dscs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dscs_pkg::S_IDLE: begin
        if (in_acc && command == dscs_pkg::CMD_COMPUTE && count_c != '0) begin
          state_next = dscs_pkg::S_ROW;
        end
      end
      dscs_pkg::S_ROW: begin
        state_next = dscs_pkg::S_ROW_WAIT;
      end
      dscs_pkg::S_ROW_WAIT: begin
        state_next = (lo_c < hi_c) ? dscs_pkg::S_EDGE : dscs_pkg::S_EMIT;
      end
      dscs_pkg::S_EDGE: begin
        state_next = dscs_pkg::S_EDGE_WAIT;
      end
      dscs_pkg::S_EDGE_WAIT: begin
        state_next = dscs_pkg::S_MAC_NOW;
      end
      dscs_pkg::S_MAC_NOW: begin
        state_next = dscs_pkg::S_MAC_NEXT;
      end
      dscs_pkg::S_MAC_NEXT: begin
        state_next = dscs_pkg::S_ACC_NEXT;
      end
      dscs_pkg::S_ACC_NEXT: begin
        state_next = edge_done_c ? dscs_pkg::S_EMIT : dscs_pkg::S_EDGE;
      end
      dscs_pkg::S_EMIT: begin
        if (emit_ok) begin
          state_next = last_c ? dscs_pkg::S_IDLE : dscs_pkg::S_ROW;
        end
      end
      default: begin
        state_next = dscs_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall      = 1'b1;
    row_rd        = 1'b0;
    row_load      = 1'b0;
    edge_rd       = 1'b0;
    hist_rd       = 1'b0;
    hist_sel      = 1'b0;
    edge_step     = 1'b0;
    emit_load     = 1'b0;
    compute_start = 1'b0;
    mac_ctrl      = '0;
    case (state)
      dscs_pkg::S_IDLE: begin
        in_stall      = 1'b0;
        compute_start = in_acc && command == dscs_pkg::CMD_COMPUTE;
      end
      dscs_pkg::S_ROW: begin
        row_rd = 1'b1;
      end
      dscs_pkg::S_ROW_WAIT: begin
        row_load       = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      dscs_pkg::S_EDGE: begin
        edge_rd = 1'b1;
      end
      dscs_pkg::S_EDGE_WAIT: begin
        hist_rd = 1'b1;
      end
      dscs_pkg::S_MAC_NOW: begin
        mac_ctrl.mul_en = 1'b1;
      end
      dscs_pkg::S_MAC_NEXT: begin
        hist_sel        = 1'b1;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.add_en = 1'b1;
      end
      dscs_pkg::S_ACC_NEXT: begin
        mac_ctrl.add_en   = 1'b1;
        mac_ctrl.add_next = 1'b1;
        edge_step         = 1'b1;
      end
      dscs_pkg::S_EMIT: begin
        emit_load = emit_ok;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Output register; a held word stays until the receiver takes it.
  always_comb begin
    if (emit_load) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      target_node   <= 6'(node_idx);
      coupling_now  <= acc_now;
      coupling_next <= acc_next;
      last          <= last_c;
    end
  end

endmodule
